>>> rtl/adc_channel_scan_sequencer_top_assert.svh
// Assertion macros used by the checker file
`ifndef ADC_CHANNEL_SCAN_SEQUENCER_TOP_ASSERT_SVH
`define ADC_CHANNEL_SCAN_SEQUENCER_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define ACSS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define ACSS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/acss_pkg.sv
package acss_pkg;

    localparam int NUM_CHANNELS = 6;
    localparam int CH_BITS      = 3;
    localparam int SAMPLE_BITS  = 10;
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_BITS    = 1;
    localparam int QCNT_BITS    = 2;

    localparam logic OP_CONVERT  = 1'b0;
    localparam logic OP_SERVICE  = 1'b1;
    localparam logic KIND_MUX    = 1'b0;
    localparam logic KIND_REPORT = 1'b1;

    localparam logic REG_ENABLE_MASK   = 1'b0;
    localparam logic REG_FIRST_CHANNEL = 1'b1;

    typedef enum logic {
        ST_IDLE,
        ST_DRAIN
    } t_state;

    typedef struct packed {
        logic                   op;
        logic [SAMPLE_BITS-1:0] sample;
    } t_cmd;

    typedef struct packed {
        logic [NUM_CHANNELS-1:0] enable_mask;
        logic [CH_BITS-1:0]      first_channel;
        logic                    load_first;
        logic [CH_BITS-1:0]      load_value;
    } t_cfg;

    typedef struct packed {
        logic                   kind;
        logic [CH_BITS-1:0]     mux_channel;
        logic                   batch_done;
        logic [CH_BITS-1:0]     report_channel;
        logic [SAMPLE_BITS-1:0] report_value;
        logic                   last;
    } t_result;

    function automatic logic [CH_BITS-1:0] clamp_channel(input logic [CH_BITS-1:0] v);
        logic [CH_BITS-1:0] res;
        res = v;
        if (v >= CH_BITS'(NUM_CHANNELS)) begin
            res = CH_BITS'(NUM_CHANNELS - 1);
        end
        return res;
    endfunction

    function automatic logic [CH_BITS-1:0] next_channel(
        input logic [CH_BITS-1:0]      cur,
        input logic [NUM_CHANNELS-1:0] mask
    );
        logic [CH_BITS:0]   cand;
        logic               found;
        logic [CH_BITS-1:0] res;
        res   = cur;
        found = 1'b0;
        for (int k = 1; k <= NUM_CHANNELS; k++) begin
            cand = {1'b0, cur} + (CH_BITS+1)'(k);
            if (cand >= (CH_BITS+1)'(NUM_CHANNELS)) begin
                cand = cand - (CH_BITS+1)'(NUM_CHANNELS);
            end
            if (!found && mask[cand[CH_BITS-1:0]]) begin
                found = 1'b1;
                res   = cand[CH_BITS-1:0];
            end
        end
        return res;
    endfunction

endpackage

>>> rtl/acss_front.sv
module acss_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic          i_op,
    input  logic [9:0]    i_sample,
    output logic          o_cmd_valid,
    output acss_pkg::t_cmd o_cmd,
    input  logic          i_cmd_pop
);
    import acss_pkg::*;

    t_cmd                 r_mem [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] r_wr_ptr;
    logic [QPTR_BITS-1:0] r_rd_ptr;
    logic [QCNT_BITS-1:0] r_count;
    logic                 w_push;
    logic                 w_pop;
    t_cmd                 w_cmd;

    always_comb begin
        w_cmd.op     = (i_op == OP_SERVICE) ? OP_SERVICE : OP_CONVERT;
        w_cmd.sample = i_sample;
    end

    assign o_ready     = (r_count != QCNT_BITS'(QUEUE_DEPTH));
    assign o_cmd_valid = (r_count != '0);
    assign o_cmd       = r_mem[r_rd_ptr];
    assign w_push      = i_valid && o_ready;
    assign w_pop       = i_cmd_pop && o_cmd_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_BITS'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_BITS'(1);
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + QCNT_BITS'(1);
                2'b01:   r_count <= r_count - QCNT_BITS'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= w_cmd;
        end
    end

endmodule

>>> rtl/acss_back.sv
module acss_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  acss_pkg::t_cfg    i_cfg,
    input  logic              i_cmd_valid,
    input  acss_pkg::t_cmd    i_cmd,
    output logic              o_cmd_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output acss_pkg::t_result o_result
);
    import acss_pkg::*;

    t_state                  r_state;
    t_state                  n_state;
    logic [CH_BITS-1:0]      r_cur_ch;
    logic [CH_BITS-1:0]      n_cur_ch;
    logic [NUM_CHANNELS-1:0] r_pending;
    logic [NUM_CHANNELS-1:0] n_pending;
    logic [SAMPLE_BITS-1:0]  r_value [NUM_CHANNELS];
    logic                    r_out_valid;
    logic                    n_out_valid;
    t_result                 r_out;
    t_result                 n_out;
    logic                    w_slot_free;
    logic                    w_wr_en;
    logic [CH_BITS-1:0]      w_low_ch;
    logic [CH_BITS-1:0]      w_next_ch;

    assign w_slot_free = !r_out_valid || i_ready;
    assign w_next_ch   = next_channel(r_cur_ch, i_cfg.enable_mask);

    always_comb begin
        w_low_ch = '0;
        for (int c = NUM_CHANNELS - 1; c >= 0; c--) begin
            if (r_pending[c]) begin
                w_low_ch = CH_BITS'(c);
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        n_cur_ch    = r_cur_ch;
        n_pending   = r_pending;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_ready;
        o_cmd_pop   = 1'b0;
        w_wr_en     = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    if (i_cmd.op == OP_CONVERT) begin
                        if (w_slot_free) begin
                            o_cmd_pop            = 1'b1;
                            w_wr_en              = 1'b1;
                            n_pending            = r_pending | (NUM_CHANNELS'(1) << r_cur_ch);
                            n_cur_ch             = w_next_ch;
                            n_out.kind           = KIND_MUX;
                            n_out.mux_channel    = w_next_ch;
                            n_out.batch_done     = (w_next_ch == i_cfg.first_channel);
                            n_out.report_channel = '0;
                            n_out.report_value   = '0;
                            n_out.last           = 1'b1;
                            n_out_valid          = 1'b1;
                        end
                    end else begin
                        o_cmd_pop = 1'b1;
                        if (r_pending != '0) begin
                            n_state = ST_DRAIN;
                        end
                    end
                end
            end
            ST_DRAIN: begin
                if (w_slot_free) begin
                    n_pending            = r_pending & ~(NUM_CHANNELS'(1) << w_low_ch);
                    n_out.kind           = KIND_REPORT;
                    n_out.mux_channel    = '0;
                    n_out.batch_done     = 1'b0;
                    n_out.report_channel = w_low_ch;
                    n_out.report_value   = r_value[w_low_ch];
                    n_out.last           = (n_pending == '0);
                    n_out_valid          = 1'b1;
                    if (n_pending == '0) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        if (i_cfg.load_first) begin
            n_cur_ch = i_cfg.load_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cur_ch    <= '0;
            r_pending   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cur_ch    <= n_cur_ch;
            r_pending   <= n_pending;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (w_wr_en) begin
            r_value[r_cur_ch] <= i_cmd.sample;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

>>> rtl/adc_channel_scan_sequencer_top.sv
// Round-robin ADC scan sequencer.
// Input stream (s_axis): tuser = operation (0 conversion done, 1 service),
// tdata[9:0] = sample of the channel currently on the mux.
// Output stream (m_axis): tuser = kind (0 mux advance, 1 channel report),
// tlast marks the final result of an input transaction, tdata holds
// mux_channel, batch_done, report_channel and report_value.
// APB: register 0 at 0x0 is the channel enable mask, register 1 at 0x4 the
// first channel; writing it also moves the scan to that channel.
// A conversion transaction puts one mux advance result on m_axis, from the
// output register after the queue; conversions sustain one per cycle while
// m_axis_tready is high.
// A service transaction with N pending channels enters the drain state and
// gives N reports in ascending channel order, one per cycle while m_axis_tready
// is high, with tlast on the final one; with nothing pending it gives no result.
// A two-entry queue sits between the input stage and the sequencer, so input
// keeps flowing until it fills while the output register is stalled.
// Reset clears pending flags, mask and first channel, and empties the queue.
module adc_channel_scan_sequencer_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [9:0] sample
    input  logic        s_axis_tuser,   // [0] operation
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [2:0] mux_channel, [3] batch_done,
                                        // [6:4] report_channel, [16:7] report_value
    output logic        m_axis_tuser,   // [0] kind
    output logic        m_axis_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import acss_pkg::*;

    logic [NUM_CHANNELS-1:0] r_enable_mask;
    logic [CH_BITS-1:0]      r_first_ch;
    logic                    w_wr;
    logic                    w_reg_sel;
    logic [CH_BITS-1:0]      w_first_in;
    t_cfg                    w_cfg;
    logic                    w_cmd_valid;
    t_cmd                    w_cmd;
    logic                    w_cmd_pop;
    t_result                 w_result;

    assign pready     = 1'b1;
    assign w_reg_sel  = paddr[2];
    assign w_wr       = psel && penable && pwrite && pready;
    assign w_first_in = clamp_channel(pwdata[CH_BITS-1:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable_mask <= '0;
            r_first_ch    <= '0;
        end else if (w_wr) begin
            case (w_reg_sel)
                REG_ENABLE_MASK:   r_enable_mask <= pwdata[NUM_CHANNELS-1:0];
                REG_FIRST_CHANNEL: r_first_ch    <= w_first_in;
                default:           r_first_ch    <= r_first_ch;
            endcase
        end
    end

    always_comb begin
        case (w_reg_sel)
            REG_ENABLE_MASK:   prdata = 32'(r_enable_mask);
            REG_FIRST_CHANNEL: prdata = 32'(r_first_ch);
            default:           prdata = '0;
        endcase
    end

    always_comb begin
        w_cfg.enable_mask   = r_enable_mask;
        w_cfg.first_channel = r_first_ch;
        w_cfg.load_first    = w_wr && (w_reg_sel == REG_FIRST_CHANNEL);
        w_cfg.load_value    = w_first_in;
    end

    acss_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_op        (s_axis_tuser),
        .i_sample    (s_axis_tdata[SAMPLE_BITS-1:0]),
        .o_cmd_valid (w_cmd_valid),
        .o_cmd       (w_cmd),
        .i_cmd_pop   (w_cmd_pop)
    );

    acss_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_cmd_pop   (w_cmd_pop),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_result    (w_result)
    );

    assign m_axis_tdata = {7'b0, w_result.report_value, w_result.report_channel,
                           w_result.batch_done, w_result.mux_channel};
    assign m_axis_tuser = w_result.kind;
    assign m_axis_tlast = w_result.last;

endmodule

>>> rtl/acss_checker.sv
`include "adc_channel_scan_sequencer_top_assert.svh"

module acss_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [23:0] m_axis_tdata,
    input  logic        m_axis_tuser,
    input  logic        m_axis_tlast
);
    import acss_pkg::*;

    `ACSS_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "stalled result changed")
    `ACSS_ASSERT_NOW(a_mux_last, m_axis_tvalid && (m_axis_tuser == KIND_MUX), m_axis_tlast && (m_axis_tdata[23:4] == 20'd0), "mux advance result malformed")
    `ACSS_ASSERT_NOW(a_report_fields, m_axis_tvalid && (m_axis_tuser == KIND_REPORT), (m_axis_tdata[3:0] == 4'd0) && (m_axis_tdata[23:17] == 7'd0), "report result malformed")
    `ACSS_ASSERT_NOW(a_channel_range, m_axis_tvalid, (m_axis_tdata[2:0] < 3'(NUM_CHANNELS)) && (m_axis_tdata[6:4] < 3'(NUM_CHANNELS)), "channel out of range")

endmodule

bind adc_channel_scan_sequencer_top acss_checker u_acss_checker (.*);

>>> sim/tb.sv
module tb;

    import acss_pkg::*;

    logic        i_clk;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata  = '0;    // [9:0] sample
    logic        s_axis_tuser  = 1'b0;  // [0] operation
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;          // [2:0] mux_channel, [3] batch_done,
                                        // [6:4] report_channel, [16:7] report_value
    logic        m_axis_tuser;          // [0] kind
    logic        m_axis_tlast;
    logic        psel          = 1'b0;
    logic        penable       = 1'b0;
    logic        pwrite        = 1'b0;
    logic [2:0]  paddr         = '0;
    logic [31:0] pwdata        = '0;
    logic [31:0] prdata;
    logic        pready;

    adc_channel_scan_sequencer_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // scan state mirrored from the sequencer
    logic [NUM_CHANNELS-1:0] scan_mask;
    logic [CH_BITS-1:0]      scan_first;
    logic [CH_BITS-1:0]      scan_cur;
    logic [SAMPLE_BITS-1:0]  ch_sample [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] ch_pending;

    t_result scan_results_due[$];
    t_result due_r;

    int errors;
    int n_convert;
    int n_service;
    int n_reports;
    int n_wraps;
    int stall_left;
    bit quiet;

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    initial begin
        #2_000_000;
        $display("tb: FAIL");
        $finish;
    end

    function automatic void check_field(input string what, input int unsigned exp_v,
                                        input int unsigned act_v);
        if (exp_v != act_v) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, what, exp_v, act_v);
        end
    endfunction

    task automatic advance_scan(input logic op, input logic [SAMPLE_BITS-1:0] smp);
        t_result r;
        logic [CH_BITS-1:0] nx;
        int c;
        int n;
        n = 0;
        if (op == OP_CONVERT) begin
            ch_sample[scan_cur]  = smp;
            ch_pending[scan_cur] = 1'b1;
            nx = scan_cur;
            for (int k = NUM_CHANNELS; k >= 1; k--) begin
                c = (int'(scan_cur) + k) % NUM_CHANNELS;
                if (scan_mask[c]) nx = CH_BITS'(c);
            end
            scan_cur = nx;
            r = '0;
            r.kind = KIND_MUX;
            r.mux_channel = nx;
            r.batch_done = (nx == scan_first);
            r.last = 1'b1;
            scan_results_due.push_back(r);
            n_convert++;
        end else begin
            for (c = 0; c < NUM_CHANNELS; c++) begin
                if (ch_pending[c]) begin
                    r = '0;
                    r.kind = KIND_REPORT;
                    r.report_channel = CH_BITS'(c);
                    r.report_value = ch_sample[c];
                    scan_results_due.push_back(r);
                    ch_pending[c] = 1'b0;
                    n++;
                end
            end
            if (n > 0) scan_results_due[scan_results_due.size()-1].last = 1'b1;
            n_service++;
        end
    endtask

    task automatic send_item(input logic op, input logic [SAMPLE_BITS-1:0] smp);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'b0, smp};
        s_axis_tuser  <= op;
        do @(posedge i_clk); while (!s_axis_tready);
        advance_scan(op, smp);
    endtask

    task automatic drain_scan();
        s_axis_tvalid <= 1'b0;
        while (scan_results_due.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
    endtask

    task automatic set_scan_config(input logic [31:0] mask_word, input logic [31:0] first_word);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {REG_ENABLE_MASK, 2'b00};
        pwdata  <= mask_word;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        scan_mask = mask_word[NUM_CHANNELS-1:0];
        penable <= 1'b0;
        paddr   <= {REG_FIRST_CHANNEL, 2'b00};
        pwdata  <= first_word;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        scan_first = (first_word[CH_BITS-1:0] >= CH_BITS'(NUM_CHANNELS)) ?
                     CH_BITS'(NUM_CHANNELS - 1) : first_word[CH_BITS-1:0];
        scan_cur = scan_first;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // reset state: nothing enabled, scan parked on channel 0
    task automatic test_no_channels_enabled();
        send_item(OP_CONVERT, 10'h000);
        send_item(OP_CONVERT, 10'h3FF);
        send_item(OP_SERVICE, 10'h3FF);
        send_item(OP_SERVICE, 10'h000);
        drain_scan();
    endtask

    task automatic test_full_scan_extremes();
        set_scan_config(32'h0000_003F, 32'h0000_0000);
        send_item(OP_CONVERT, 10'h3FF);
        send_item(OP_CONVERT, 10'h000);
        send_item(OP_CONVERT, 10'h2AA);
        send_item(OP_CONVERT, 10'h155);
        send_item(OP_CONVERT, 10'h001);
        send_item(OP_CONVERT, 10'h200);
        send_item(OP_SERVICE, 10'h155);
        drain_scan();
    endtask

    // disabled start channel, saturated first channel, ignored upper write bits
    task automatic test_sparse_mask();
        set_scan_config(32'hFFFF_FFC5, 32'hFFFF_FFFF);
        send_item(OP_CONVERT, 10'h123);
        send_item(OP_CONVERT, 10'h3FE);
        send_item(OP_CONVERT, 10'h0F0);
        send_item(OP_SERVICE, 10'h2AA);
        send_item(OP_CONVERT, 10'h00F);
        send_item(OP_SERVICE, 10'h3FF);
        drain_scan();
        set_scan_config(32'h0000_0020, 32'h0000_0006);
        send_item(OP_CONVERT, 10'h1FF);
        send_item(OP_CONVERT, 10'h200);
        send_item(OP_SERVICE, 10'h000);
        drain_scan();
    endtask

    task automatic test_random_scan();
        logic [31:0] mask_word;
        logic [31:0] first_word;
        logic        op;
        logic [SAMPLE_BITS-1:0] smp;
        for (int phase = 0; phase < 6; phase++) begin
            mask_word  = {26'($urandom()), 6'($urandom_range(0, 63))};
            first_word = {29'($urandom()), 3'($urandom_range(0, 7))};
            case (phase)
                0: mask_word[5:0] = 6'h3F;
                1: mask_word[5:0] = 6'h00;
                2: mask_word[5:0] = 6'(1 << $urandom_range(0, NUM_CHANNELS - 1));
                default: ;
            endcase
            if (phase == 0) first_word[2:0] = 3'd0;
            quiet = (phase == 3);
            set_scan_config(mask_word, first_word);
            for (int i = 0; i < 26; i++) begin
                op = ($urandom_range(0, 3) == 0) ? OP_SERVICE : OP_CONVERT;
                case ($urandom_range(0, 7))
                    0: smp = '0;
                    1: smp = '1;
                    default: smp = SAMPLE_BITS'($urandom());
                endcase
                send_item(op, smp);
            end
            send_item(OP_SERVICE, SAMPLE_BITS'($urandom()));
            drain_scan();
        end
        quiet = 1'b0;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            stall_left    <= 0;
        end else if (m_axis_tready) begin
            if (m_axis_tvalid && !quiet && $urandom_range(0, 2) != 0) begin
                m_axis_tready <= 1'b0;
                stall_left    <= $urandom_range(1, 11);
            end
        end else begin
            if (stall_left <= 1) m_axis_tready <= 1'b1;
            stall_left <= stall_left - 1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (scan_results_due.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none actual tuser=%0d tdata=%h",
                         $time, m_axis_tuser, m_axis_tdata);
            end else begin
                due_r = scan_results_due.pop_front();
                check_field("kind", due_r.kind, m_axis_tuser);
                check_field("mux_channel", due_r.mux_channel, m_axis_tdata[2:0]);
                check_field("batch_done", due_r.batch_done, m_axis_tdata[3]);
                check_field("report_channel", due_r.report_channel, m_axis_tdata[6:4]);
                check_field("report_value", due_r.report_value, m_axis_tdata[16:7]);
                check_field("last", due_r.last, m_axis_tlast);
                check_field("tdata padding", 0, m_axis_tdata[23:17]);
                if (due_r.kind == KIND_REPORT) n_reports++;
                if (due_r.kind == KIND_MUX && due_r.batch_done) n_wraps++;
            end
        end
    end

    initial begin
        errors     = 0;
        n_convert  = 0;
        n_service  = 0;
        n_reports  = 0;
        n_wraps    = 0;
        quiet      = 1'b0;
        scan_mask  = '0;
        scan_first = '0;
        scan_cur   = '0;
        ch_pending = '0;
        for (int c = 0; c < NUM_CHANNELS; c++) ch_sample[c] = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_no_channels_enabled();
        test_full_scan_extremes();
        test_sparse_mask();
        test_random_scan();
        $display("tb: %0d conversions and %0d service requests sent over several scan setups,",
                 n_convert, n_service);
        $display("tb: %0d channel reports and %0d batch wraps checked", n_reports, n_wraps);
        if (errors == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule
